FILE: sv/pose_error_spike_ema_filter_defines.svh
`ifndef POSE_ERROR_SPIKE_EMA_FILTER_DEFINES_SVH
`define POSE_ERROR_SPIKE_EMA_FILTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PESEF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pesef assertion failed");

// Check that cons holds in the cycle after ante.
`define PESEF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pesef assertion failed");

`endif

FILE: sv/pesef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pesef_pkg;

    localparam int PESEF_ERROR_WIDTH = 16;
    localparam int ALPHA_W           = 9;
    localparam int LIMIT_W           = 15;
    localparam int RUN_W             = 4;
    localparam int HOLD_W            = 16;
    localparam int TIME_W            = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

    localparam logic [ALPHA_W-1:0] RST_EMA_ALPHA         = ALPHA_W'(64);
    localparam logic [LIMIT_W-1:0] RST_SPIKE_LIMIT_Y     = LIMIT_W'(1024);
    localparam logic [LIMIT_W-1:0] RST_SPIKE_LIMIT_HEAD  = LIMIT_W'(1024);
    localparam logic [RUN_W-1:0]   RST_OUTLIER_RUN_LIMIT = RUN_W'(5);
    localparam logic [LIMIT_W-1:0] RST_TOLERANCE_X       = LIMIT_W'(205);
    localparam logic [LIMIT_W-1:0] RST_TOLERANCE_Y       = LIMIT_W'(328);
    localparam logic [LIMIT_W-1:0] RST_TOLERANCE_HEAD    = LIMIT_W'(328);
    localparam logic [HOLD_W-1:0]  RST_HOLD_MS           = HOLD_W'(2000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMA_ALPHA         = 3'd0,
        REG_SPIKE_LIMIT_Y     = 3'd1,
        REG_SPIKE_LIMIT_HEAD  = 3'd2,
        REG_OUTLIER_RUN_LIMIT = 3'd3,
        REG_TOLERANCE_X       = 3'd4,
        REG_TOLERANCE_Y       = 3'd5,
        REG_TOLERANCE_HEAD    = 3'd6,
        REG_HOLD_MS           = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        VERDICT_DRIVE = 2'd0,
        VERDICT_STOP  = 2'd1,
        VERDICT_FAIL  = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] ema_alpha;
        logic [LIMIT_W-1:0] spike_limit_y;
        logic [LIMIT_W-1:0] spike_limit_heading;
        logic [RUN_W-1:0]   outlier_run_limit;
        logic [LIMIT_W-1:0] tolerance_x;
        logic [LIMIT_W-1:0] tolerance_y;
        logic [LIMIT_W-1:0] tolerance_heading;
        logic [HOLD_W-1:0]  hold_ms;
    } cfg_t;

    typedef struct packed {
        verdict_t verdict;
        logic     success;
        logic     failure;
    } judge_t;

endpackage

`default_nettype wire

FILE: sv/pesef_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pesef_cfg_regs
    import pesef_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_EMA_ALPHA:         cfg_next.ema_alpha           = cfg_wdata[ALPHA_W-1:0];
                REG_SPIKE_LIMIT_Y:     cfg_next.spike_limit_y       = cfg_wdata[LIMIT_W-1:0];
                REG_SPIKE_LIMIT_HEAD:  cfg_next.spike_limit_heading = cfg_wdata[LIMIT_W-1:0];
                REG_OUTLIER_RUN_LIMIT: cfg_next.outlier_run_limit   = cfg_wdata[RUN_W-1:0];
                REG_TOLERANCE_X:       cfg_next.tolerance_x         = cfg_wdata[LIMIT_W-1:0];
                REG_TOLERANCE_Y:       cfg_next.tolerance_y         = cfg_wdata[LIMIT_W-1:0];
                REG_TOLERANCE_HEAD:    cfg_next.tolerance_heading   = cfg_wdata[LIMIT_W-1:0];
                REG_HOLD_MS:           cfg_next.hold_ms             = cfg_wdata[HOLD_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ema_alpha           <= RST_EMA_ALPHA;
            cfg_reg.spike_limit_y       <= RST_SPIKE_LIMIT_Y;
            cfg_reg.spike_limit_heading <= RST_SPIKE_LIMIT_HEAD;
            cfg_reg.outlier_run_limit   <= RST_OUTLIER_RUN_LIMIT;
            cfg_reg.tolerance_x         <= RST_TOLERANCE_X;
            cfg_reg.tolerance_y         <= RST_TOLERANCE_Y;
            cfg_reg.tolerance_heading   <= RST_TOLERANCE_HEAD;
            cfg_reg.hold_ms             <= RST_HOLD_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/pesef_ema.sv
`timescale 1ns / 1ps
`default_nettype none

module pesef_ema
    import pesef_pkg::*;
#(
    parameter int ERROR_WIDTH = PESEF_ERROR_WIDTH
)
(
    input  logic signed [ERROR_WIDTH-1:0] cand,
    input  logic signed [ERROR_WIDTH-1:0] held,
    input  logic        [ALPHA_W-1:0]     alpha,
    output logic signed [ERROR_WIDTH-1:0] blended
);

    localparam int PW = ERROR_WIDTH + ALPHA_W + 1;

    logic signed [ALPHA_W:0]  a_s;
    logic signed [ALPHA_W:0]  b_s;
    logic signed [PW-1:0]     prod_cand;
    logic signed [PW-1:0]     prod_held;
    logic signed [PW-1:0]     sum;
    logic signed [PW-1:0]     shifted;

    always_comb
    begin
        a_s       = $signed({1'b0, alpha});
        b_s       = $signed({1'b0, ALPHA_ONE}) - a_s;
        prod_cand = a_s * cand;
        prod_held = b_s * held;
        sum       = prod_cand + prod_held;
        // floor division by 256
        shifted   = sum >>> 8;
        blended   = shifted[ERROR_WIDTH-1:0];
    end

endmodule

`default_nettype wire

FILE: sv/pesef_filter.sv
`timescale 1ns / 1ps
`default_nettype none

module pesef_filter
    import pesef_pkg::*;
#(
    parameter int ERROR_WIDTH = PESEF_ERROR_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  cfg_t                          cfg,
    input  logic signed [ERROR_WIDTH-1:0] cand_x,
    input  logic signed [ERROR_WIDTH-1:0] cand_y,
    input  logic signed [ERROR_WIDTH-1:0] cand_heading,
    output logic signed [ERROR_WIDTH-1:0] held_x_next,
    output logic signed [ERROR_WIDTH-1:0] held_y_next,
    output logic signed [ERROR_WIDTH-1:0] held_heading_next,
    output logic                          spike_next
);

    localparam int DW = (ERROR_WIDTH + 1 > LIMIT_W) ? ERROR_WIDTH + 1 : LIMIT_W;

    logic signed [ERROR_WIDTH-1:0] held_x_reg;
    logic signed [ERROR_WIDTH-1:0] held_y_reg;
    logic signed [ERROR_WIDTH-1:0] held_heading_reg;
    logic                          primed_reg;
    logic [RUN_W-1:0]              run_reg;
    logic [RUN_W-1:0]              run_next;

    logic [ALPHA_W-1:0]            alpha_sat;
    logic signed [ERROR_WIDTH-1:0] ema_x;
    logic signed [ERROR_WIDTH-1:0] ema_y;
    logic signed [ERROR_WIDTH-1:0] ema_heading;
    logic signed [ERROR_WIDTH:0]   diff_y;
    logic signed [ERROR_WIDTH:0]   diff_heading;
    logic [ERROR_WIDTH:0]          mag_y;
    logic [ERROR_WIDTH:0]          mag_heading;
    logic [RUN_W-1:0]              run_inc;
    logic                          run_full;
    logic                          adopt;

    assign alpha_sat = (cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha;

    pesef_ema #(.ERROR_WIDTH(ERROR_WIDTH)) u_ema_x
    (
        .cand    (cand_x),
        .held    (held_x_reg),
        .alpha   (alpha_sat),
        .blended (ema_x)
    );

    pesef_ema #(.ERROR_WIDTH(ERROR_WIDTH)) u_ema_y
    (
        .cand    (cand_y),
        .held    (held_y_reg),
        .alpha   (alpha_sat),
        .blended (ema_y)
    );

    pesef_ema #(.ERROR_WIDTH(ERROR_WIDTH)) u_ema_heading
    (
        .cand    (cand_heading),
        .held    (held_heading_reg),
        .alpha   (alpha_sat),
        .blended (ema_heading)
    );

    always_comb
    begin
        diff_y       = {cand_y[ERROR_WIDTH-1], cand_y}
                     - {held_y_reg[ERROR_WIDTH-1], held_y_reg};
        diff_heading = {cand_heading[ERROR_WIDTH-1], cand_heading}
                     - {held_heading_reg[ERROR_WIDTH-1], held_heading_reg};
        mag_y        = diff_y[ERROR_WIDTH] ? $unsigned(-diff_y) : $unsigned(diff_y);
        mag_heading  = diff_heading[ERROR_WIDTH] ? $unsigned(-diff_heading)
                                                 : $unsigned(diff_heading);

        spike_next = primed_reg &&
                     ((DW'(mag_y) > DW'(cfg.spike_limit_y)) ||
                      (DW'(mag_heading) > DW'(cfg.spike_limit_heading)));

        run_inc  = run_reg + RUN_W'(1);
        run_full = run_inc >= cfg.outlier_run_limit;
        adopt    = !primed_reg || (spike_next && run_full);

        if (adopt)
        begin
            held_x_next       = cand_x;
            held_y_next       = cand_y;
            held_heading_next = cand_heading;
        end
        else if (spike_next)
        begin
            held_x_next       = held_x_reg;
            held_y_next       = held_y_reg;
            held_heading_next = held_heading_reg;
        end
        else
        begin
            held_x_next       = ema_x;
            held_y_next       = ema_y;
            held_heading_next = ema_heading;
        end

        run_next = (spike_next && !run_full) ? run_inc : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            held_heading_reg <= '0;
            primed_reg       <= 1'b0;
            run_reg          <= '0;
        end
        else if (step)
        begin
            held_x_reg       <= held_x_next;
            held_y_reg       <= held_y_next;
            held_heading_reg <= held_heading_next;
            primed_reg       <= 1'b1;
            run_reg          <= run_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pesef_judge.sv
`timescale 1ns / 1ps
`default_nettype none

module pesef_judge
    import pesef_pkg::*;
#(
    parameter int ERROR_WIDTH = PESEF_ERROR_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  cfg_t                          cfg,
    input  logic signed [ERROR_WIDTH-1:0] held_x,
    input  logic signed [ERROR_WIDTH-1:0] held_y,
    input  logic signed [ERROR_WIDTH-1:0] held_heading,
    input  logic [TIME_W-1:0]             time_ms,
    output judge_t                        judge
);

    localparam int TW = (ERROR_WIDTH > LIMIT_W) ? ERROR_WIDTH : LIMIT_W;

    logic              started_reg;
    logic [TIME_W-1:0] onset_reg;
    logic              success_reg;
    logic              failure_reg;

    logic [ERROR_WIDTH-1:0] mag_x;
    logic [ERROR_WIDTH-1:0] mag_y;
    logic [ERROR_WIDTH-1:0] mag_heading;
    logic                   x_in;
    logic                   y_in;
    logic                   y_out;
    logic                   heading_in;
    logic                   arrive;
    logic                   lateral_fail;
    logic [TIME_W-1:0]      onset;
    logic [TIME_W-1:0]      elapsed;

    always_comb
    begin
        mag_x       = held_x[ERROR_WIDTH-1] ? $unsigned(-held_x) : $unsigned(held_x);
        mag_y       = held_y[ERROR_WIDTH-1] ? $unsigned(-held_y) : $unsigned(held_y);
        mag_heading = held_heading[ERROR_WIDTH-1] ? $unsigned(-held_heading)
                                                  : $unsigned(held_heading);

        x_in       = TW'(mag_x) < TW'(cfg.tolerance_x);
        y_in       = TW'(mag_y) < TW'(cfg.tolerance_y);
        y_out      = TW'(mag_y) > TW'(cfg.tolerance_y);
        heading_in = TW'(mag_heading) < TW'(cfg.tolerance_heading);

        arrive       = x_in && y_in && heading_in;
        lateral_fail = !arrive && x_in && y_out;

        onset   = started_reg ? onset_reg : time_ms;
        elapsed = time_ms - onset;

        if (arrive)
        begin
            judge.verdict = VERDICT_STOP;
        end
        else if (lateral_fail)
        begin
            judge.verdict = VERDICT_FAIL;
        end
        else
        begin
            judge.verdict = VERDICT_DRIVE;
        end
        judge.success = success_reg || (arrive && (elapsed > TIME_W'(cfg.hold_ms)));
        judge.failure = failure_reg || lateral_fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            onset_reg   <= '0;
            success_reg <= 1'b0;
            failure_reg <= 1'b0;
        end
        else if (step)
        begin
            if (arrive && !started_reg)
            begin
                started_reg <= 1'b1;
                onset_reg   <= time_ms;
            end
            success_reg <= judge.success;
            failure_reg <= judge.failure;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pose_error_spike_ema_filter.sv
// Datapath: an accepted input word is held in the input register, which feeds the filter
// and judge logic; these load the result register when it is empty or being read out.
// Throughput: one word per cycle unless the output stalls; input and result registers
// decouple the channels, so one input word is still taken while a result is stalled.
// Reset: asynchronous active low; clears filter state, arrival and latches,
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none
`include "pose_error_spike_ema_filter_defines.svh"

module pose_error_spike_ema_filter
    import pesef_pkg::*;
#(
    parameter int ERROR_WIDTH = PESEF_ERROR_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ERROR_WIDTH-1:0] cand_x,
    input  logic signed [ERROR_WIDTH-1:0] cand_y,
    input  logic signed [ERROR_WIDTH-1:0] cand_heading,
    input  logic [TIME_W-1:0]             time_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ERROR_WIDTH-1:0] filt_x,
    output logic signed [ERROR_WIDTH-1:0] filt_y,
    output logic signed [ERROR_WIDTH-1:0] filt_heading,
    output logic                          spike,
    output logic [1:0]                    verdict,
    output logic                          success,
    output logic                          failure
);

    cfg_t cfg;

    logic                          in_valid_reg;
    logic signed [ERROR_WIDTH-1:0] in_x_reg;
    logic signed [ERROR_WIDTH-1:0] in_y_reg;
    logic signed [ERROR_WIDTH-1:0] in_heading_reg;
    logic [TIME_W-1:0]             in_time_reg;

    logic                          out_valid_reg;
    logic signed [ERROR_WIDTH-1:0] out_x_reg;
    logic signed [ERROR_WIDTH-1:0] out_y_reg;
    logic signed [ERROR_WIDTH-1:0] out_heading_reg;
    logic                          out_spike_reg;
    verdict_t                      out_verdict_reg;
    logic                          out_success_reg;
    logic                          out_failure_reg;

    logic                          advance;
    logic                          step;
    logic                          in_take;
    logic signed [ERROR_WIDTH-1:0] held_x_next;
    logic signed [ERROR_WIDTH-1:0] held_y_next;
    logic signed [ERROR_WIDTH-1:0] held_heading_next;
    logic                          spike_next;
    judge_t                        judge_next;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    pesef_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pesef_filter #(.ERROR_WIDTH(ERROR_WIDTH)) u_filter
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .cfg               (cfg),
        .cand_x            (in_x_reg),
        .cand_y            (in_y_reg),
        .cand_heading      (in_heading_reg),
        .held_x_next       (held_x_next),
        .held_y_next       (held_y_next),
        .held_heading_next (held_heading_next),
        .spike_next        (spike_next)
    );

    pesef_judge #(.ERROR_WIDTH(ERROR_WIDTH)) u_judge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .cfg          (cfg),
        .held_x       (held_x_next),
        .held_y       (held_y_next),
        .held_heading (held_heading_next),
        .time_ms      (in_time_reg),
        .judge        (judge_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_x_reg       <= cand_x;
            in_y_reg       <= cand_y;
            in_heading_reg <= cand_heading;
            in_time_reg    <= time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            out_success_reg <= 1'b0;
            out_failure_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (step)
            begin
                out_success_reg <= judge_next.success;
                out_failure_reg <= judge_next.failure;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_x_reg       <= held_x_next;
            out_y_reg       <= held_y_next;
            out_heading_reg <= held_heading_next;
            out_spike_reg   <= spike_next;
            out_verdict_reg <= judge_next.verdict;
        end
    end

    assign out_valid    = out_valid_reg;
    assign filt_x       = out_x_reg;
    assign filt_y       = out_y_reg;
    assign filt_heading = out_heading_reg;
    assign spike        = out_spike_reg;
    assign verdict      = out_verdict_reg;
    assign success      = out_success_reg;
    assign failure      = out_failure_reg;

    `PESEF_ASSERT_NXT(a_success_sticky, success, success)
    `PESEF_ASSERT_NXT(a_failure_sticky, failure, failure)
    `PESEF_ASSERT_IMP(a_fail_latched, out_valid && (verdict == VERDICT_FAIL), failure)
    `PESEF_ASSERT_NXT(a_word_kept, in_valid_reg && !advance, in_valid_reg)

endmodule

`default_nettype wire
